// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/ptts_pkg.sv -----
// Shared types and codes for the periodic task tick scheduler.
// No dependencies; every other file of the block but assert_macros.svh refers to it by scoped names.
package ptts_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_SUSPEND = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    localparam logic [1:0] ST_DELETED   = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_SUSPENDED = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  task_id;
        logic [15:0] period;
        logic [15:0] initial_delay;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] fire_mask;
        logic [1:0] task_status;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] period;
        logic [15:0] countdown;
    } t_slot;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        hit;
        logic [15:0] period;
        logic [15:0] initial_delay;
    } t_upd_ctl;

endpackage

// ----- src/ptts_cell.sv -----
// One task slot of the circulating slot ring.
// Depends on ptts_pkg for the slot type.
module ptts_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  ptts_pkg::t_slot i_slot,
    output ptts_pkg::t_slot o_slot
);

    ptts_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.status    <= ptts_pkg::ST_DELETED;
            r_slot.period    <= 16'd0;
            r_slot.countdown <= 16'd0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- src/ptts_slot_update.sv -----
// Applies the current operation to the slot leaving the head of the ring.
// Depends on ptts_pkg for opcodes, status codes and the slot type.
module ptts_slot_update (
    input  ptts_pkg::t_upd_ctl i_ctl,
    input  ptts_pkg::t_slot    i_slot,
    output ptts_pkg::t_slot    o_slot,
    output logic               o_fire,
    output logic [1:0]         o_status
);

    always_comb begin
        o_slot   = i_slot;
        o_fire   = 1'b0;
        o_status = ptts_pkg::ST_DELETED;
        unique case (i_ctl.opcode)
            ptts_pkg::OP_TICK: begin
                if (i_slot.status == ptts_pkg::ST_READY) begin
                    if (i_slot.countdown == 16'd0) begin
                        o_fire           = 1'b1;
                        o_slot.countdown = i_slot.period - 16'd1;
                    end else begin
                        o_slot.countdown = i_slot.countdown - 16'd1;
                    end
                end
            end
            ptts_pkg::OP_CREATE: begin
                if (i_ctl.hit) begin
                    o_slot.status    = ptts_pkg::ST_READY;
                    o_slot.period    = i_ctl.period;
                    o_slot.countdown = i_ctl.initial_delay;
                end
            end
            ptts_pkg::OP_DELETE: begin
                if (i_ctl.hit) begin
                    o_slot.status = ptts_pkg::ST_DELETED;
                end
            end
            ptts_pkg::OP_SUSPEND: begin
                if (i_ctl.hit) begin
                    o_slot.status = ptts_pkg::ST_SUSPENDED;
                end
            end
            ptts_pkg::OP_RESUME: begin
                if (i_ctl.hit) begin
                    o_slot.status = ptts_pkg::ST_READY;
                end
            end
            ptts_pkg::OP_QUERY: begin
                if (i_ctl.hit) begin
                    o_status = i_slot.status;
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

// ----- src/periodic_task_tick_scheduler_unit.sv -----
// Periodic task tick scheduler. An accepted beat is worked through a ring and an
// output register: the task slots sit in a ring of cells that rotates once per
// item, one slot per cycle passing the update logic at the head, and then the
// output register is loaded. The input then reopens, so a new beat is taken
// only after the last one is done. A stalled output that is still full when
// the next result is done holds the block until that result beat leaves.
// A finished result waits in an output register while the next beat is taken.
// Depends on ptts_pkg, ptts_cell and ptts_slot_update.
module periodic_task_tick_scheduler_unit #(
    parameter int NUM_TASKS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptts_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ptts_pkg::t_out_beat o_out_data
);

    localparam int CW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int IW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_step;
    ptts_pkg::t_in_beat  r_item;
    logic [7:0]          r_fire;
    logic [1:0]          r_stat;
    logic                r_out_valid;
    ptts_pkg::t_out_beat r_out_data;

    ptts_pkg::t_slot     w_ring [NUM_TASKS];
    ptts_pkg::t_slot     w_upd_slot;
    ptts_pkg::t_upd_ctl  w_ctl;
    logic                w_fire;
    logic [1:0]          w_stat;
    logic [IW-1:0]       w_idx;
    logic                w_shift;
    logic                w_accept;
    logic                w_last;
    logic                w_load;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_shift  = (r_state == S_RUN);
    assign w_last   = (r_step == CW'(NUM_TASKS - 1));
    assign w_load   = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);
    assign w_idx    = IW'(r_step);

    assign w_ctl.opcode        = r_item.opcode;
    assign w_ctl.hit           = (w_idx == IW'(r_item.task_id));
    assign w_ctl.period        = r_item.period;
    assign w_ctl.initial_delay = r_item.initial_delay;

    for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
        ptts_pkg::t_slot w_next;
        if (k == NUM_TASKS - 1) begin : g_tail
            assign w_next = w_upd_slot;
        end else begin : g_mid
            assign w_next = w_ring[k + 1];
        end
        ptts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_slot  (w_next),
            .o_slot  (w_ring[k])
        );
    end

    ptts_slot_update u_update (
        .i_ctl    (w_ctl),
        .i_slot   (w_ring[0]),
        .o_slot   (w_upd_slot),
        .o_fire   (w_fire),
        .o_status (w_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
            r_step <= '0;
            r_fire <= 8'd0;
            r_stat <= 2'd0;
        end else if (w_shift) begin
            r_step <= r_step + CW'(1);
            if (w_fire && (w_idx[IW-1:3] == '0)) begin
                r_fire[w_idx[2:0]] <= 1'b1;
            end
            r_stat <= r_stat | w_stat;
        end
        if (w_load) begin
            r_out_data.fire_mask   <= r_fire;
            r_out_data.task_status <= r_stat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- src/ptts_checker.sv -----
// Port-level checks for the periodic task tick scheduler, bound to the top level.
// Depends on ptts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ptts_pkg::t_out_beat o_out_data
);

    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_SAME(a_status_code, o_out_valid, o_out_data.task_status != 2'd3)
    `ASSERT_SAME(a_one_field, o_out_valid, o_out_data.fire_mask == 8'd0 || o_out_data.task_status == 2'd0)

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
